// ----- hdl/ais_pkg.sv -----
`default_nettype none
package ais_pkg;
	localparam int DEPTH = 16;
	localparam int VALUE_BITS = 32;
	localparam int IDX_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] sorted_value;
		logic end_of_set;
	} out_item_t;

	// front-to-back command: value plus whether it closes the set
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic close;
	} cmd_t;
endpackage
`default_nettype wire

// ----- hdl/ais_if.sv -----
`default_nettype none
interface ais_in_if;
	logic valid;
	logic ready;
	logic signed [ais_pkg::VALUE_BITS-1:0] value;
	logic last;
	modport source(output valid, value, last, input ready);
	modport sink(input valid, value, last, output ready);
endinterface

interface ais_out_if;
	logic valid;
	logic ready;
	logic signed [ais_pkg::VALUE_BITS-1:0] sorted_value;
	logic end_of_set;
	modport source(output valid, sorted_value, end_of_set, input ready);
	modport sink(input valid, sorted_value, end_of_set, output ready);
endinterface
`default_nettype wire

// ----- hdl/ais_front.sv -----
`default_nettype none
module ais_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	ais_in_if.sink          in_ch,
	output ais_pkg::cmd_t   cmd,
	output logic            cmd_valid,
	input  wire logic       cmd_ready
);
	import ais_pkg::*;

	logic [CNT_BITS-1:0] count_q;
	logic                fire;
	logic [CNT_BITS-1:0] count_inc;

	assign in_ch.ready = cmd_ready;
	assign cmd_valid   = in_ch.valid;
	assign fire        = in_ch.valid && cmd_ready;
	assign count_inc   = count_q + CNT_BITS'(1);
	assign cmd.value   = in_ch.value;
	assign cmd.close   = in_ch.last || (count_inc == CNT_BITS'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= cmd.close ? '0 : count_inc;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ais_queue.sv -----
`default_nettype none
module ais_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  ais_pkg::cmd_t wr_data,
	input  wire logic     wr_valid,
	output logic          wr_ready,
	output ais_pkg::cmd_t rd_data,
	output logic          rd_valid,
	input  wire logic     rd_ready
);
	import ais_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic           wp_q, rp_q;
	logic [1:0]     fill_q;
	logic           wr_en, rd_en;

	assign wr_ready = fill_q != 2'(QDEPTH);
	assign rd_valid = fill_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= ~wp_q;
			end
			if (rd_en) begin
				rp_q <= ~rp_q;
			end
			fill_q <= fill_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ais_back.sv -----
`default_nettype none
module ais_back (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  ais_pkg::cmd_t cmd,
	input  wire logic     cmd_valid,
	output logic          cmd_ready,
	ais_out_if.source     out_ch
);
	import ais_pkg::*;

	localparam logic LOADING  = 1'b0;
	localparam logic EMITTING = 1'b1;

	logic                         state_q;
	logic signed [VALUE_BITS-1:0] cell_q [DEPTH];
	logic [CNT_BITS-1:0]          count_q;
	logic                         take;
	logic                         pop;
	logic [DEPTH-1:0]             gt;
	logic [DEPTH-1:1]             first;

	assign cmd_ready     = (state_q == LOADING);
	assign take          = cmd_valid && cmd_ready;
	assign out_ch.valid  = (state_q == EMITTING);
	assign out_ch.sorted_value = cell_q[0];
	assign out_ch.end_of_set   = (count_q == CNT_BITS'(1));
	assign pop           = out_ch.valid && out_ch.ready;

	// insertion cell chain: cells hold ascending values, the new value drops
	// into place and larger ones shift up
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CNT_BITS'(i) >= count_q) || (cell_q[i] > cmd.value);
		end
		for (int i = 1; i < DEPTH; i++) begin
			first[i] = gt[i] && !gt[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (gt[0]) begin
				cell_q[0] <= cmd.value;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (first[i]) begin
					cell_q[i] <= cmd.value;
				end else if (gt[i]) begin
					cell_q[i] <= cell_q[i-1];
				end
			end
		end else if (pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				cell_q[i] <= cell_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOADING;
			count_q <= '0;
		end else if (take) begin
			count_q <= count_q + CNT_BITS'(1);
			if (cmd.close) begin
				state_q <= EMITTING;
			end
		end else if (pop) begin
			count_q <= count_q - CNT_BITS'(1);
			if (count_q == CNT_BITS'(1)) begin
				state_q <= LOADING;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ascending_integer_sorter.sv -----
// Ascending integer sorter.
// Input channel (in_ch): valid/ready with a signed value and a last flag.
// A set closes on last, or on the DEPTH-th item (16), whichever comes first.
// Output channel (out_ch): valid/ready, the set in ascending order, one
// item per cycle while out_ch.ready is high, end_of_set high on the
// final (largest) item. Loading: one item per cycle while the chain loads;
// an insertion cell chain places each value as it arrives. A two-entry
// queue between the input front end and the cell chain lets the front end
// keep taking items while the chain emits. Results start once the closing
// item has passed the queue and the chain has switched to emitting;
// the cell chain either loads or emits, never both.
// Reset: asynchronous, active low; clears counts and returns to loading.
// Cell contents are not cleared.
// Receiver stall: output holds; the chain waits, the queue fills, then
// in_ch.ready drops.
`default_nettype none
module ascending_integer_sorter (
	input  wire logic clk,
	input  wire logic arst_n,
	ais_in_if.sink    in_ch,
	ais_out_if.source out_ch
);
	import ais_pkg::*;

	cmd_t f_cmd, q_cmd;
	logic f_valid, f_ready, q_valid, q_ready;

	ais_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
	);

	ais_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	ais_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
		.out_ch(out_ch)
	);
endmodule
`default_nettype wire

// ----- dv/ais_if.sv -----
`timescale 1ns / 100ps

// ----- dv/ascending_integer_sorter_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module ascending_integer_sorter_test;
	import ais_pkg::*;

	class sorted_set_board;
		logic signed [VALUE_BITS-1:0] pending[$];
		out_item_t sorted_q[$];
		int mismatches;

		function void note_item(logic signed [VALUE_BITS-1:0] v, logic lst);
			logic signed [VALUE_BITS-1:0] t;
			out_item_t r;
			pending.push_back(v);
			if (lst || pending.size() >= DEPTH) begin
				for (int i = 1; i < pending.size(); i++) begin
					t = pending[i];
					for (int j = i; j > 0 && pending[j-1] > t; j--) begin
						pending[j] = pending[j-1];
						pending[j-1] = t;
					end
				end
				for (int k = 0; k < pending.size(); k++) begin
					r.sorted_value = pending[k];
					r.end_of_set = (k == pending.size() - 1);
					sorted_q.push_back(r);
				end
				pending.delete();
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (sorted_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d/%0b", got.sorted_value, got.end_of_set);
				return;
			end
			e = sorted_q.pop_front();
			if (got.sorted_value !== e.sorted_value || got.end_of_set !== e.end_of_set) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %0d/%0b got %0d/%0b", e.sorted_value,
						e.end_of_set, got.sorted_value, got.end_of_set);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	ais_in_if in_ch();
	ais_out_if out_ch();
	sorted_set_board board = new();
	bit stim_done = 0;

	ascending_integer_sorter dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.value = 0;
		in_ch.last = 0;
		out_ch.ready = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [VALUE_BITS-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
			1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
			2: return $urandom_range(0, 6) - 3;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(logic signed [VALUE_BITS-1:0] v, logic lst, bit quiet);
		int g;
		g = quiet ? 0 : gap_len();
		if (g > 0) begin
			in_ch.valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.value <= v;
		in_ch.last <= lst;
		do @(posedge clk); while (!in_ch.ready);
		board.note_item(v, lst);
	endtask

	task automatic send_set(int n, bit close_last, bit quiet);
		for (int i = 0; i < n; i++)
			send_item(rand_value(), close_last && i == n - 1, quiet);
	endtask

	initial begin
		int n;
		@(posedge arst_n);
		@(posedge clk);
		send_item(5, 1, 0);
		send_item({1'b1, {(VALUE_BITS-1){1'b0}}}, 0, 0);
		send_item({1'b0, {(VALUE_BITS-1){1'b1}}}, 0, 0);
		send_item(0, 0, 0);
		send_item(-1, 0, 0);
		send_item(-1, 1, 0);
		send_set(DEPTH, 0, 1);
		in_ch.valid <= 0;
		while (board.sorted_q.size() != 0) @(posedge clk);
		for (int s = 0; s < 30; s++) begin
			n = ($urandom_range(0, 4) == 0) ? DEPTH : $urandom_range(1, DEPTH - 1);
			send_set(n, n != DEPTH || $urandom_range(0, 1), $urandom_range(0, 3) == 0);
		end
		send_item($urandom, 1, 0);
		in_ch.valid <= 0;
		stim_done = 1;
	end

	initial begin
		int g;
		forever begin
			g = gap_len();
			if (g > 0) begin
				out_ch.ready <= 0;
				repeat (g) @(posedge clk);
			end
			out_ch.ready <= 1;
			g = $urandom_range(1, 20);
			repeat (g) begin
				@(posedge clk);
				if (out_ch.valid && out_ch.ready)
					board.check_result('{sorted_value: out_ch.sorted_value,
						end_of_set: out_ch.end_of_set});
			end
		end
	end

	initial begin
		wait (stim_done);
		while (board.sorted_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.mismatches == 0 && board.sorted_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
